// ===== rtl/core/bced_pkg.sv =====
package bced_pkg;

   typedef enum logic [1:0] {
      PH_IDLE   = 2'd0,
      PH_DOWN   = 2'd1,
      PH_UP     = 2'd2,
      PH_DOUBLE = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      PV_NONE   = 2'd0,
      PV_DOWN   = 2'd1,
      PV_DOUBLE = 2'd2,
      PV_LONG   = 2'd3
   } prev_type;

   typedef enum logic [2:0] {
      EV_NONE      = 3'd0,
      EV_DOWN      = 3'd1,
      EV_RELEASE   = 3'd2,
      EV_DOUBLE    = 3'd3,
      EV_LONG      = 3'd4,
      EV_LONG_FREE = 3'd5
   } event_type;

   localparam logic [2:0] CSR_TRIGGER_LEVEL       = 3'd0;
   localparam logic [2:0] CSR_INITIAL_LEVEL       = 3'd1;
   localparam logic [2:0] CSR_DEBOUNCE_TICKS      = 3'd2;
   localparam logic [2:0] CSR_LONG_TICKS          = 3'd3;
   localparam logic [2:0] CSR_DOUBLE_TICKS        = 3'd4;
   localparam logic [2:0] CSR_POWER_BUTTON        = 3'd5;
   localparam logic [2:0] CSR_CLICK_AFTER_WINDOW  = 3'd6;
   localparam logic [2:0] CSR_LONG_RELEASE_SILENT = 3'd7;

   localparam logic [7:0] POWER_LONG_TICKS = 8'd200;
   localparam logic [7:0] HOLD_CEILING     = 8'hFF;

   typedef struct packed {
      logic       trigger_level;
      logic       initial_level;
      logic [7:0] debounce_ticks;
      logic [7:0] long_ticks;
      logic [7:0] double_ticks;
      logic       power_button;
      logic       click_after_window;
      logic       long_release_silent;
   } cfg_type;

   typedef struct packed {
      logic       stable_level;
      logic [7:0] debounce_count;
      phase_type  press_phase;
      prev_type   previous_phase;
      event_type  last_event;
      logic [7:0] hold_count;
      logic [7:0] window_count;
   } state_type;

   typedef struct packed {
      event_type event_first;
      event_type event_second;
      phase_type press_state;
      event_type trigger_event;
   } result_type;

endpackage

// ===== rtl/core/bced_step.sv =====
module bced_step
   import bced_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  logic       level,
   output state_type  state_nxt,
   output result_type result
);

   typedef struct packed {
      event_type  ev0;
      event_type  ev1;
      logic [1:0] cnt;
   } ev_pair_type;

   // Appends an event; a third one in the same tick is dropped.
   function automatic ev_pair_type push(ev_pair_type p, event_type e);
      ev_pair_type q;
      q = p;
      if (p.cnt == 2'd0) begin
         q.ev0 = e;
         q.cnt = 2'd1;
      end else if (p.cnt == 2'd1) begin
         q.ev1 = e;
         q.cnt = 2'd2;
      end
      return q;
   endfunction

   always_comb begin
      state_type   s;
      ev_pair_type ev;
      s  = state_cur;
      ev = '{ev0: EV_NONE, ev1: EV_NONE, cnt: 2'd0};

      // Debounce: the counter only moves while the level differs.
      if (level != s.stable_level) begin
         s.debounce_count = s.debounce_count + 8'd1;
         if (s.debounce_count >= cfg.debounce_ticks) begin
            s.stable_level   = level;
            s.debounce_count = 8'd0;
            if (s.press_phase == PH_IDLE || s.press_phase == PH_DOUBLE) begin
               s.press_phase = PH_DOWN;
            end else if (s.press_phase == PH_DOWN) begin
               s.press_phase = PH_UP;
               ev = push(ev, EV_RELEASE);
            end
         end
      end

      if (s.press_phase == PH_DOWN && s.stable_level == cfg.trigger_level) begin
         s.last_event = EV_DOWN;
         s.hold_count = s.hold_count + 8'd1;
         if (!cfg.power_button) begin
            if (s.hold_count >= cfg.long_ticks) begin
               if (s.previous_phase != PV_LONG) begin
                  s.last_event     = EV_LONG;
                  ev               = push(ev, EV_LONG);
                  s.hold_count     = 8'd0;
                  s.previous_phase = PV_LONG;
               end else begin
                  ev = push(ev, EV_DOWN);
               end
               if (s.hold_count == HOLD_CEILING) s.hold_count = cfg.long_ticks;
            end
         end else begin
            if (s.hold_count >= POWER_LONG_TICKS) begin
               if (s.previous_phase != PV_LONG) begin
                  s.last_event     = EV_LONG;
                  ev               = push(ev, EV_LONG);
                  s.hold_count     = 8'd0;
                  s.press_phase    = PH_IDLE;
                  s.previous_phase = PV_LONG;
               end
               if (s.hold_count == HOLD_CEILING) s.hold_count = cfg.long_ticks;
            end
         end
      end else if (s.press_phase == PH_DOWN || s.press_phase == PH_UP) begin
         // Release handling; a down phase whose level is not pressed lands here too.
         if (s.last_event == EV_DOWN) begin
            if (s.window_count <= cfg.double_ticks && s.previous_phase == PV_DOUBLE) begin
               s.last_event     = EV_DOUBLE;
               ev               = push(ev, EV_DOUBLE);
               s.press_phase    = PH_IDLE;
               s.previous_phase = PV_NONE;
            end else begin
               s.window_count = 8'd0;
               s.hold_count   = 8'd0;
               if (!cfg.click_after_window) ev = push(ev, EV_DOWN);
               s.press_phase    = PH_DOUBLE;
               s.previous_phase = PV_DOUBLE;
            end
         end else if (s.last_event == EV_LONG) begin
            if (!cfg.long_release_silent) ev = push(ev, EV_LONG_FREE);
            s.hold_count     = 8'd0;
            s.press_phase    = PH_IDLE;
            s.previous_phase = PV_NONE;
         end
      end else if (s.press_phase == PH_DOUBLE) begin
         s.window_count = s.window_count + 8'd1;
         if (s.window_count >= cfg.double_ticks) begin
            s.press_phase    = PH_IDLE;
            s.previous_phase = PV_NONE;
         end
         if (cfg.click_after_window && s.window_count >= cfg.double_ticks &&
             s.previous_phase != PV_DOWN) begin
            s.window_count   = 8'd0;
            ev               = push(ev, EV_DOWN);
            s.press_phase    = PH_IDLE;
            s.previous_phase = PV_DOWN;
         end
      end

      state_nxt            = s;
      result.event_first   = ev.ev0;
      result.event_second  = ev.ev1;
      result.press_state   = s.press_phase;
      result.trigger_event = s.last_event;
   end

endmodule

// ===== rtl/core/button_click_event_detector_core.sv =====
// Channel   Direction  Transaction content
// req_*     in         one scan tick: sampled button level
// rsp_*     out        one result per tick: two events, press phase, last trigger
// csr_*     in         register write, no wait and no read-back
//
// Each tick passes through the input register, then through the press logic into
// the result register. The press state updates as the tick leaves the input
// register, so a new tick is accepted every cycle unless the result is stalled.
// A stalled result holds in the output register while one more tick waits at
// the input. Reset is synchronous and loads the register defaults.
module button_click_event_detector_core
   import bced_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [0] level, [7:1] zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,   // [2:0] event_first, [5:3] event_second,
                                    // [7:6] press_state, [10:8] trigger_event,
                                    // [15:11] zero
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   cfg_type    cfg_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type rsp_ff;
   logic       in_valid_ff;
   logic       level_ff;
   logic       rsp_valid_ff;
   logic       advance;

   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {5'd0, rsp_ff.trigger_event, rsp_ff.press_state,
                        rsp_ff.event_second, rsp_ff.event_first};

   bced_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .level     (level_ff),
      .state_nxt (state_in),
      .result    (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) level_ff <= req_tdata[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) rsp_ff <= result_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_level       <= 1'b0;
         cfg_ff.initial_level       <= 1'b1;
         cfg_ff.debounce_ticks      <= 8'd3;
         cfg_ff.long_ticks          <= 8'd50;
         cfg_ff.double_ticks        <= 8'd15;
         cfg_ff.power_button        <= 1'b0;
         cfg_ff.click_after_window  <= 1'b0;
         cfg_ff.long_release_silent <= 1'b0;
         state_ff.stable_level      <= 1'b1;
         state_ff.debounce_count    <= 8'd0;
         state_ff.press_phase       <= PH_IDLE;
         state_ff.previous_phase    <= PV_NONE;
         state_ff.last_event        <= EV_NONE;
         state_ff.hold_count        <= 8'd0;
         state_ff.window_count      <= 8'd0;
      end else begin
         if (advance) state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TRIGGER_LEVEL:       cfg_ff.trigger_level       <= csr_wdata[0];
               CSR_INITIAL_LEVEL: begin
                  // Writing the initial level also reloads the stable level.
                  cfg_ff.initial_level  <= csr_wdata[0];
                  state_ff.stable_level <= csr_wdata[0];
               end
               CSR_DEBOUNCE_TICKS:      cfg_ff.debounce_ticks      <= csr_wdata;
               CSR_LONG_TICKS:          cfg_ff.long_ticks          <= csr_wdata;
               CSR_DOUBLE_TICKS:        cfg_ff.double_ticks        <= csr_wdata;
               CSR_POWER_BUTTON:        cfg_ff.power_button        <= csr_wdata[0];
               CSR_CLICK_AFTER_WINDOW:  cfg_ff.click_after_window  <= csr_wdata[0];
               CSR_LONG_RELEASE_SILENT: cfg_ff.long_release_silent <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

endmodule

// ===== tb/sv/tb.sv =====
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bced_pkg::*;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int PRINT_LIMIT    = 40;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // [0] level, [7:1] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;         // [2:0] event_first, [5:3] event_second,
                                   // [7:6] press_state, [10:8] trigger_event
   logic        csr_we     = 1'b0;
   logic [2:0]  csr_index  = '0;
   logic [7:0]  csr_wdata  = '0;

   // Mirror of the button state, updated on every accepted tick, and of its settings.
   state_type   btn;
   cfg_type     settings;
   event_type   tick_events [2];
   int          tick_event_count;

   result_type  tick_reports [$];
   int          ticks_sent  = 0;
   int          mismatches  = 0;
   int          idle_cycles = 0;
   bit          calm        = 1'b0;

   button_click_event_detector_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #10 clock = ~clock;

   function automatic void restart_predictor();
      settings = '0;
      settings.initial_level  = 1'b1;
      settings.debounce_ticks = 8'd3;
      settings.long_ticks     = 8'd50;
      settings.double_ticks   = 8'd15;
      btn = '0;
      btn.stable_level = settings.initial_level;
   endfunction

   function automatic void apply_register(input logic [2:0] idx, input logic [7:0] val);
      case (idx)
         CSR_TRIGGER_LEVEL:       settings.trigger_level = val[0];
         CSR_INITIAL_LEVEL: begin
            settings.initial_level = val[0];
            btn.stable_level = val[0];
         end
         CSR_DEBOUNCE_TICKS:      settings.debounce_ticks = val;
         CSR_LONG_TICKS:          settings.long_ticks = val;
         CSR_DOUBLE_TICKS:        settings.double_ticks = val;
         CSR_POWER_BUTTON:        settings.power_button = val[0];
         CSR_CLICK_AFTER_WINDOW:  settings.click_after_window = val[0];
         CSR_LONG_RELEASE_SILENT: settings.long_release_silent = val[0];
         default: ;
      endcase
   endfunction

   function automatic void note_event(input event_type e);
      if (tick_event_count < 2) begin
         tick_events[tick_event_count] = e;
         tick_event_count++;
      end
   endfunction

   // Rules that run once the button is seen released.
   function automatic void release_rules();
      if (btn.last_event == EV_DOWN) begin
         if (btn.window_count <= settings.double_ticks && btn.previous_phase == PV_DOUBLE) begin
            btn.last_event = EV_DOUBLE;
            note_event(EV_DOUBLE);
            btn.press_phase = PH_IDLE;
            btn.previous_phase = PV_NONE;
         end else begin
            btn.window_count = '0;
            btn.hold_count = '0;
            if (!settings.click_after_window) note_event(EV_DOWN);
            btn.press_phase = PH_DOUBLE;
            btn.previous_phase = PV_DOUBLE;
         end
      end else if (btn.last_event == EV_LONG) begin
         if (!settings.long_release_silent) note_event(EV_LONG_FREE);
         btn.hold_count = '0;
         btn.press_phase = PH_IDLE;
         btn.previous_phase = PV_NONE;
      end
   endfunction

   function automatic result_type scan_tick(input logic lvl);
      result_type r;
      logic [7:0] hold_limit;
      tick_events[0] = EV_NONE;
      tick_events[1] = EV_NONE;
      tick_event_count = 0;
      hold_limit = settings.power_button ? POWER_LONG_TICKS : settings.long_ticks;

      if (lvl != btn.stable_level) begin
         btn.debounce_count = btn.debounce_count + 8'd1;
         if (btn.debounce_count >= settings.debounce_ticks) begin
            btn.stable_level = lvl;
            btn.debounce_count = '0;
            if (btn.press_phase == PH_IDLE || btn.press_phase == PH_DOUBLE) begin
               btn.press_phase = PH_DOWN;
            end else if (btn.press_phase == PH_DOWN) begin
               btn.press_phase = PH_UP;
               note_event(EV_RELEASE);
            end
         end
      end

      case (btn.press_phase)
         PH_DOWN: begin
            if (btn.stable_level == settings.trigger_level) begin
               btn.last_event = EV_DOWN;
               btn.hold_count = btn.hold_count + 8'd1;
               if (btn.hold_count >= hold_limit) begin
                  if (btn.previous_phase != PV_LONG) begin
                     btn.last_event = EV_LONG;
                     note_event(EV_LONG);
                     btn.hold_count = '0;
                     btn.previous_phase = PV_LONG;
                     if (settings.power_button) btn.press_phase = PH_IDLE;
                  end else if (!settings.power_button) begin
                     note_event(EV_DOWN);
                  end
                  if (btn.hold_count == HOLD_CEILING) btn.hold_count = settings.long_ticks;
               end
            end else begin
               release_rules();
            end
         end
         PH_UP: release_rules();
         PH_DOUBLE: begin
            btn.window_count = btn.window_count + 8'd1;
            if (btn.window_count >= settings.double_ticks) begin
               btn.press_phase = PH_IDLE;
               btn.previous_phase = PV_NONE;
            end
            if (settings.click_after_window && btn.window_count >= settings.double_ticks &&
                btn.previous_phase != PV_DOWN) begin
               btn.window_count = '0;
               note_event(EV_DOWN);
               btn.press_phase = PH_IDLE;
               btn.previous_phase = PV_DOWN;
            end
         end
         default: ;
      endcase

      r.event_first   = tick_events[0];
      r.event_second  = tick_events[1];
      r.press_state   = btn.press_phase;
      r.trigger_event = btn.last_event;
      return r;
   endfunction

   // The up phase without a pending event, or a down phase that already saw the
   // released level, never gets back to idle by releasing the button.
   function automatic bit stuck_phase();
      return btn.press_phase == PH_UP ||
             (btn.press_phase == PH_DOWN && btn.stable_level != settings.trigger_level);
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      mismatches++;
      if (mismatches <= PRINT_LIMIT)
         $display("%0t: %s mismatch, got %0d, expected %0d", $realtime, what, got, want);
   endtask

   always @(posedge clock) begin
      rsp_tready <= calm || ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (tick_reports.size() == 0) begin
            report_mismatch("unexpected result", rsp_tdata[7:0], 8'd0);
         end else begin
            want = tick_reports.pop_front();
            if (rsp_tdata[2:0] !== want.event_first)
               report_mismatch("event_first", 8'(rsp_tdata[2:0]), 8'(want.event_first));
            if (rsp_tdata[5:3] !== want.event_second)
               report_mismatch("event_second", 8'(rsp_tdata[5:3]), 8'(want.event_second));
            if (rsp_tdata[7:6] !== want.press_state)
               report_mismatch("press_state", 8'(rsp_tdata[7:6]), 8'(want.press_state));
            if (rsp_tdata[10:8] !== want.trigger_event)
               report_mismatch("trigger_event", 8'(rsp_tdata[10:8]),
                               8'(want.trigger_event));
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send_tick(input logic lvl);
      while (!calm && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {7'd0, lvl};
      do @(posedge clock); while (!req_tready);
      tick_reports.push_back(scan_tick(lvl));
      ticks_sent++;
   endtask

   task automatic send_run(input logic lvl, input int n);
      repeat (n) send_tick(lvl);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (tick_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Only called with nothing in flight.
   task automatic restart_block();
      reset <= 1'b1;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      restart_predictor();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [7:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      apply_register(idx, val);
   endtask

   // The rest level is always written as the opposite of the pressed level.
   task automatic apply_settings(input logic trig, input logic [7:0] deb,
                                 input logic [7:0] lng, input logic [7:0] dbl,
                                 input logic pwr, input logic caw, input logic silent);
      write_reg(CSR_TRIGGER_LEVEL, {7'd0, trig});
      write_reg(CSR_INITIAL_LEVEL, {7'd0, ~trig});
      write_reg(CSR_DEBOUNCE_TICKS, deb);
      write_reg(CSR_LONG_TICKS, lng);
      write_reg(CSR_DOUBLE_TICKS, dbl);
      write_reg(CSR_POWER_BUTTON, {7'd0, pwr});
      write_reg(CSR_CLICK_AFTER_WINDOW, {7'd0, caw});
      write_reg(CSR_LONG_RELEASE_SILENT, {7'd0, silent});
      csr_we <= 1'b0;
   endtask

   // Keep the button released until the press machine is back in idle; a
   // machine that can no longer get there is reset.
   task automatic settle();
      int guard;
      guard = 0;
      while (btn.press_phase != PH_IDLE && !stuck_phase() && guard < 600) begin
         send_tick(~settings.trigger_level);
         guard++;
      end
      drain();
      if (btn.press_phase != PH_IDLE) restart_block();
   endtask

   task automatic random_gestures(input int budget);
      int   first_tick;
      int   deb;
      int   hold_limit;
      int   win;
      int   pick;
      logic pressed;
      first_tick = ticks_sent;
      deb        = int'(settings.debounce_ticks);
      hold_limit = settings.power_button ? int'(POWER_LONG_TICKS) :
                                           int'(settings.long_ticks);
      win        = int'(settings.double_ticks);
      pressed    = settings.trigger_level;
      while (ticks_sent - first_tick < budget) begin
         pick = $urandom_range(99);
         if (pick < 35) begin
            send_run(pressed, deb + 1 + $urandom_range(0, hold_limit - 1));
            send_run(~pressed, deb + 1 + $urandom_range(0, win + 2));
         end else if (pick < 55) begin
            send_run(pressed, deb + 1 + $urandom_range(0, 2));
            send_run(~pressed, deb + 1 + $urandom_range(0, win));
            send_run(pressed, deb + 1 + $urandom_range(0, 2));
            send_run(~pressed, deb + 1 + $urandom_range(0, win + 2));
         end else if (pick < 70) begin
            send_run(pressed, deb + hold_limit + $urandom_range(0, hold_limit + 3));
            send_run(~pressed, deb + 1 + $urandom_range(0, 3));
         end else if (pick < 85) begin
            // Contact bounce: short runs around the debounce count.
            repeat ($urandom_range(2, 6))
               send_run($urandom_range(1) != 0, $urandom_range(1, deb + 1));
         end else begin
            repeat ($urandom_range(1, 8)) send_tick($urandom_range(1) != 0);
         end
      end
   endtask

   task automatic test_directed_gestures();
      apply_settings(1'b0, 8'd1, 8'd3, 8'd3, 1'b0, 1'b0, 1'b0);
      // Single click, then the double-click window runs out.
      send_run(1'b0, 2);
      send_run(1'b1, 4);
      // Double click.
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      send_run(1'b0, 1);
      send_run(1'b1, 1);
      // Long press released right after it fires gives a long release.
      send_run(1'b0, 3);
      send_run(1'b1, 1);
      // Held past the long press: repeated down events, then a click on release.
      send_run(1'b0, 7);
      send_run(1'b1, 4);
      settle();
   endtask

   task automatic test_quick_clicks();
      apply_settings(1'b1, 8'd2, 8'd6, 8'd5, 1'b0, 1'b0, 1'b0);
      random_gestures(80);
      settle();
   endtask

   task automatic test_zero_thresholds();
      calm = 1'b1;
      apply_settings(1'b1, 8'd0, 8'd1, 8'd0, 1'b0, 1'b1, 1'b0);
      random_gestures(60);
      settle();
      calm = 1'b0;
   endtask

   task automatic test_silent_long_release();
      apply_settings(1'b0, 8'd1, 8'd4, 8'd8, 1'b0, 1'b1, 1'b1);
      random_gestures(60);
      settle();
   endtask

   task automatic test_default_timing();
      apply_settings(1'b0, 8'd3, 8'd50, 8'd15, 1'b0, 1'b0, 1'b0);
      random_gestures(40);
      settle();
   endtask

   task automatic test_power_button();
      apply_settings(1'b1, 8'd1, 8'd3, 8'd4, 1'b1, 1'b0, 1'b0);
      // Held to the fixed threshold, then released while already idle.
      send_run(1'b1, 1 + POWER_LONG_TICKS + 1);
      send_run(1'b0, 3);
      // A short click well below the fixed threshold.
      send_run(1'b1, 4);
      send_run(1'b0, 4);
      settle();
   endtask

   task automatic test_hold_ceiling();
      apply_settings(1'b0, 8'd0, 8'd4, 8'd10, 1'b0, 1'b0, 1'b0);
      // Long enough for the hold counter to reach its ceiling and be pulled back.
      send_run(1'b0, 265);
      send_run(1'b1, 2);
      random_gestures(20);
      settle();
   endtask

   task automatic test_slow_debounce();
      apply_settings(1'b1, 8'd20, 8'd1, 8'd0, 1'b0, 1'b0, 1'b1);
      random_gestures(40);
      settle();
   endtask

   // Once the trigger level matches the rest level after a double click, a
   // release leaves the machine in the up phase for the rest of the run.
   task automatic test_stuck_up_phase();
      apply_settings(1'b0, 8'd1, 8'd10, 8'd6, 1'b0, 1'b0, 1'b0);
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      send_run(1'b0, 2);
      send_run(1'b1, 1);
      drain();
      write_reg(CSR_TRIGGER_LEVEL, 8'd1);
      csr_we <= 1'b0;
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      send_run(1'b0, 2);
      send_run(1'b1, 2);
      drain();
   endtask

   initial begin
      restart_predictor();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed_gestures();
      test_quick_clicks();
      test_zero_thresholds();
      test_silent_long_release();
      test_default_timing();
      test_power_button();
      test_hold_ceiling();
      test_slow_debounce();
      test_stuck_up_phase();
      repeat (8) @(posedge clock);
      if (mismatches == 0 && tick_reports.size() == 0) begin
         $display("tb OK");
      end else begin
         $display("tb NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/bced_pkg.sv
rtl/core/bced_step.sv
rtl/core/button_click_event_detector_core.sv
tb/sv/tb.sv
